/* rtl/core/gmb_pkg.sv */
// gmb_pkg: shared types and constants for the grid maze reachability block.
// Used by every module under rtl/core.
package gmb_pkg;

  localparam int MAX_SIDE  = 16;
  localparam int SIDE_W    = 5;                    // holds MAX_SIDE itself
  localparam int POS_W     = 8;                    // cell index
  localparam int CNT_W     = 9;                    // holds MAX_SIDE*MAX_SIDE
  localparam int RC_W      = 4;                    // row / column
  localparam int DIST_W    = 8;
  localparam int LIMIT_W   = 16;
  localparam int CELLS     = MAX_SIDE * MAX_SIDE;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW   = 2;

  localparam logic [1:0] KIND_OPEN  = 2'd0;
  localparam logic [1:0] KIND_WALL  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_EXIT  = 2'd3;

  localparam logic REG_SIDE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  // one command from the loader to the search engine
  typedef struct packed {
    logic             wr;
    logic [POS_W-1:0] idx;
    logic             wall;
    logic             last;
    logic [CNT_W-1:0] limit;
    logic             start_ok;
    logic [POS_W-1:0] start_pos;
    logic             exit_ok;
    logic [POS_W-1:0] exit_pos;
  } gmb_cmd_t;

  // frontier entry: row, column, move count
  typedef struct packed {
    logic [RC_W-1:0]   row;
    logic [RC_W-1:0]   col;
    logic [DIST_W-1:0] moves;
  } gmb_node_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK_S, ST_CHK_E, ST_CHK_V, ST_CLEAR, ST_DIVS,
    ST_SEED, ST_POP, ST_POPW, ST_NB, ST_REPORT
  } gmb_state_t;

endpackage

/* rtl/core/gmb_front.sv */
// gmb_front: takes cells, tracks load count and start/exit, builds commands.
// Depends on gmb_pkg.
module gmb_front
  import gmb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        cell_kind,
  input  logic              last_cell,
  input  logic [SIDE_W-1:0] side,
  output gmb_cmd_t          cmd
);

  logic [CNT_W-1:0] load_count, load_count_next;
  logic             start_ok, start_ok_next, exit_ok, exit_ok_next;
  logic [POS_W-1:0] start_pos, start_pos_next, exit_pos, exit_pos_next;
  logic [2*SIDE_W-1:0] area;
  logic [CNT_W-1:0] n, lim;
  logic             in_range;

  always_comb begin
    area     = side * side;
    n        = area[CNT_W-1:0];
    in_range = load_count < n;
    load_count_next = in_range ? load_count + 1'b1 : load_count;
    lim = (load_count_next < n) ? load_count_next : n;
    start_ok_next  = start_ok;
    start_pos_next = start_pos;
    exit_ok_next   = exit_ok;
    exit_pos_next  = exit_pos;
    if (in_range && cell_kind == KIND_START) begin
      start_ok_next  = 1'b1;
      start_pos_next = load_count[POS_W-1:0];
    end
    if (in_range && cell_kind == KIND_EXIT) begin
      exit_ok_next  = 1'b1;
      exit_pos_next = load_count[POS_W-1:0];
    end
    cmd.wr        = in_range;
    cmd.idx       = load_count[POS_W-1:0];
    cmd.wall      = (cell_kind == KIND_WALL);
    cmd.last      = last_cell;
    cmd.limit     = lim;
    cmd.start_ok  = start_ok_next;
    cmd.start_pos = start_pos_next;
    cmd.exit_ok   = exit_ok_next;
    cmd.exit_pos  = exit_pos_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      start_ok   <= 1'b0;
      exit_ok    <= 1'b0;
      start_pos  <= '0;
      exit_pos   <= '0;
    end else if (accept) begin
      if (last_cell) begin
        load_count <= '0;
        start_ok   <= 1'b0;
        exit_ok    <= 1'b0;
        start_pos  <= '0;
        exit_pos   <= '0;
      end else begin
        load_count <= load_count_next;
        start_ok   <= start_ok_next;
        exit_ok    <= exit_ok_next;
        start_pos  <= start_pos_next;
        exit_pos   <= exit_pos_next;
      end
    end
  end

endmodule

/* rtl/core/gmb_fifo.sv */
// gmb_fifo: short command queue between loader and search engine.
// Depends on gmb_pkg.
module gmb_fifo
  import gmb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  gmb_cmd_t push_data,
  input  logic     pop,
  output gmb_cmd_t pop_data,
  output logic     full,
  output logic     empty
);

  gmb_cmd_t           slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full     = (count == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/core/gmb_back.sv */
// gmb_back: wall store, visited store, frontier queue and the search sequencer.
// Depends on gmb_pkg.
module gmb_back
  import gmb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_empty,
  input  gmb_cmd_t            cmd_in,
  output logic                cmd_pop,
  input  logic [SIDE_W-1:0]   side,
  input  logic [LIMIT_W-1:0]  time_limit,
  output logic                done,
  output logic                reachable,
  output logic [DIST_W-1:0]   distance,
  output logic                escapes
);

  logic      wall_mem [CELLS];
  logic      vis_mem  [CELLS];
  gmb_node_t q_mem    [CELLS];

  gmb_state_t state, state_next;
  gmb_cmd_t   cur;
  logic       wall_q, vis_q, s_wall;
  gmb_node_t  q_rd;

  logic [POS_W-1:0]  clr_cnt;
  logic [POS_W-1:0]  rem;
  logic [RC_W-1:0]   row, col;
  logic [DIST_W-1:0] cur_dist;
  logic [CNT_W-1:0]  head, tail;
  logic [2:0]        k;

  logic              cand_vld;
  logic [POS_W-1:0]  cand_q;
  logic [RC_W-1:0]   cand_r, cand_c;

  logic              res_found;
  logic [DIST_W-1:0] res_dist;

  // combinational helpers
  logic              seed_ok, head_empty, at_exit, cand_take;
  logic [2*SIDE_W-1:0] pos_prod, nb_prod;
  logic [CNT_W-1:0]  pos_now, nb_pos;
  logic [SIDE_W-1:0] nr, nc;
  logic              nb_in;
  logic              wall_re;
  logic [POS_W-1:0]  wall_ra;

  always_comb begin
    seed_ok = cur.start_ok && cur.exit_ok
              && ({1'b0, cur.start_pos} < cur.limit)
              && ({1'b0, cur.exit_pos} < cur.limit)
              && !s_wall && !wall_q;
    head_empty = (head == tail);
    pos_prod = SIDE_W'(q_rd.row) * side;
    pos_now  = pos_prod[CNT_W-1:0] + CNT_W'(q_rd.col);
    at_exit  = (pos_now == {1'b0, cur.exit_pos});

    nr = SIDE_W'(row);
    nc = SIDE_W'(col);
    nb_in = 1'b0;
    unique case (k[1:0])
      2'd0: begin nr = SIDE_W'(row) + 1'b1; nb_in = nr < side; end
      2'd1: begin nc = SIDE_W'(col) + 1'b1; nb_in = nc < side; end
      2'd2: begin nr = SIDE_W'(row) - 1'b1; nb_in = (row != '0); end
      2'd3: begin nc = SIDE_W'(col) - 1'b1; nb_in = (col != '0); end
      default: nb_in = 1'b0;
    endcase
    nb_prod = nr * side;
    nb_pos  = nb_prod[CNT_W-1:0] + CNT_W'(nc);

    cand_take = (state == ST_NB) && cand_vld
                && ({1'b0, cand_q} < cur.limit) && !wall_q && !vis_q;

    wall_re = 1'b1;
    unique case (state)
      ST_CHK_S: wall_ra = cur.start_pos;
      ST_CHK_E: wall_ra = cur.exit_pos;
      default:  wall_ra = nb_pos[POS_W-1:0];
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (!cmd_empty && cmd_in.last) state_next = ST_CHK_S;
      ST_CHK_S:  state_next = ST_CHK_E;
      ST_CHK_E:  state_next = ST_CHK_V;
      ST_CHK_V:  state_next = seed_ok ? ST_CLEAR : ST_REPORT;
      ST_CLEAR:  if (clr_cnt == POS_W'(CELLS - 1)) state_next = ST_DIVS;
      ST_DIVS:   if ({1'b0, rem} < CNT_W'(side)) state_next = ST_SEED;
      ST_SEED:   state_next = ST_POP;
      ST_POP:    state_next = head_empty ? ST_REPORT : ST_POPW;
      ST_POPW:   state_next = at_exit ? ST_REPORT : ST_NB;
      ST_NB:     if (k == 3'd4) state_next = ST_POP;
      ST_REPORT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop   = (state == ST_IDLE) && !cmd_empty;
    done      = (state == ST_REPORT);
    reachable = res_found;
    distance  = res_dist;
    escapes   = res_found && ({8'b0, res_dist} <= time_limit);
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd_in.wr) wall_mem[cmd_in.idx] <= cmd_in.wall;
    if (wall_re) wall_q <= wall_mem[wall_ra];
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR)     vis_mem[clr_cnt]       <= 1'b0;
    else if (state == ST_SEED) vis_mem[cur.start_pos] <= 1'b1;
    else if (cand_take)        vis_mem[cand_q]        <= 1'b1;
    vis_q <= vis_mem[nb_pos[POS_W-1:0]];
  end

  // the seed always lands in slot 0, the head of a fresh queue
  always_ff @(posedge clk) begin
    if (state == ST_SEED)
      q_mem[POS_W'(0)] <= '{row: row, col: rem[RC_W-1:0], moves: '0};
    else if (cand_take)
      q_mem[tail[POS_W-1:0]] <= '{row: cand_r, col: cand_c, moves: cur_dist + 1'b1};
    q_rd <= q_mem[head[POS_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (cmd_pop && cmd_in.last) cur <= cmd_in;
        res_found <= 1'b0;
        res_dist  <= '0;
      end
      ST_CHK_S: ;
      ST_CHK_E: s_wall <= wall_q;
      ST_CHK_V: begin
        clr_cnt <= '0;
        rem     <= cur.start_pos;
        row     <= '0;
      end
      ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
      ST_DIVS: begin
        // start row/column by repeated subtraction, one step a cycle
        if ({1'b0, rem} >= CNT_W'(side)) begin
          rem <= rem - POS_W'(side);
          row <= row + 1'b1;
        end
      end
      ST_SEED: begin
        head <= '0;
        tail <= CNT_W'(1);
      end
      ST_POP: if (!head_empty) head <= head + 1'b1;
      ST_POPW: begin
        row      <= q_rd.row;
        col      <= q_rd.col;
        cur_dist <= q_rd.moves;
        k        <= '0;
        cand_vld <= 1'b0;
        if (at_exit) begin
          res_found <= 1'b1;
          res_dist  <= q_rd.moves;
        end
      end
      ST_NB: begin
        if (cand_take) tail <= tail + 1'b1;
        cand_vld <= (k != 3'd4) && nb_in;
        cand_q   <= nb_pos[POS_W-1:0];
        cand_r   <= nr[RC_W-1:0];
        cand_c   <= nc[RC_W-1:0];
        k        <= k + 1'b1;
      end
      ST_REPORT: ;
      default: ;
    endcase
  end

endmodule

/* rtl/core/grid_maze_bfs_reach.sv */
// grid_maze_bfs_reach: maze loader, command queue and breadth-first search.
// Cells are taken one per cycle while the queue has room (busy when full).
// On the last cell the search runs: wall checks, a clear of all 256 visited
// cells, start located by subtraction, then neighbour checks per dequeued
// cell; the result strobes done for one cycle. The receiver cannot stall.
// rst (synchronous) empties the queue and loads side 16, time limit 0.
module grid_maze_bfs_reach
  import gmb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cell_kind,
  input  logic               last_cell,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [LIMIT_W-1:0] wr_data,
  output logic               done,
  output logic               reachable,
  output logic [DIST_W-1:0]  distance,
  output logic               escapes
);

  logic [SIDE_W-1:0]  side_length;
  logic [LIMIT_W-1:0] time_limit;
  logic [SIDE_W-1:0]  side;
  logic               accept, full, empty, pop;
  gmb_cmd_t           f_cmd, b_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= SIDE_W'(MAX_SIDE);
      time_limit  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SIDE:  side_length <= wr_data[SIDE_W-1:0];
        REG_LIMIT: time_limit  <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (side_length < SIDE_W'(2))             side = SIDE_W'(2);
    else if (side_length > SIDE_W'(MAX_SIDE)) side = SIDE_W'(MAX_SIDE);
    else                                      side = side_length;
  end

  assign busy   = full;
  assign accept = start && !full;

  gmb_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .cell_kind(cell_kind),
    .last_cell(last_cell), .side(side), .cmd(f_cmd)
  );

  gmb_fifo u_fifo (
    .clk(clk), .rst(rst), .push(accept), .push_data(f_cmd), .pop(pop),
    .pop_data(b_cmd), .full(full), .empty(empty)
  );

  gmb_back u_back (
    .clk(clk), .rst(rst), .cmd_empty(empty), .cmd_in(b_cmd), .cmd_pop(pop),
    .side(side), .time_limit(time_limit), .done(done), .reachable(reachable),
    .distance(distance), .escapes(escapes)
  );

endmodule
